// File: src/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and codes for the measurement run sequencer.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_TIME_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIP_TRIGGER_PCT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIP_DWELL_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE_TO_MS  = 3'd5;

  localparam logic       CMD_START = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic       MODE_TIMED      = 1'b0;
  localparam logic       MODE_PEAK_FORCE = 1'b1;

  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_TIME    = 2'd1;
  localparam logic [1:0] STOP_SLIP    = 2'd2;
  localparam logic [1:0] STOP_TIMEOUT = 2'd3;

  // tenths of a degree
  localparam logic signed [13:0] TEMP_BAND = 14'sd20;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAT = 2'd1,
    PH_MEAS = 2'd2
  } phase_t;

  typedef struct packed {
    logic        command;
    logic        temp_valid;
    logic [11:0] temp_sample;
    logic        slip_valid;
    logic [23:0] commanded_um;
    logic [23:0] measured_um;
  } in_item_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       heater_allowed;
    logic       begin_pulse;
    logic       end_pulse;
    logic [1:0] stop_reason;
    logic       slip_excess;
  } out_item_t;

  typedef struct packed {
    logic [11:0] target_temp;
    logic        run_mode;
    logic [31:0] measure_time_ms;
    logic [6:0]  slip_trigger_pct;
    logic [15:0] slip_dwell_ms;
    logic [23:0] force_limit_ms;
  } cfg_t;

endpackage

// File: src/msr_cfg.sv
// ----------------------------------------------------------------------------
// msr_cfg
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module msr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [msr_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0]   wr_data,
  output msr_pkg::cfg_t                    cfg
);
  import msr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp      <= 12'd1800;
      cfg.run_mode         <= MODE_TIMED;
      cfg.measure_time_ms  <= 32'd0;
      cfg.slip_trigger_pct <= 7'd5;
      cfg.slip_dwell_ms    <= 16'd2000;
      cfg.force_limit_ms   <= 24'd120000;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TARGET_TEMP:      cfg.target_temp      <= wr_data[11:0];
        CFG_RUN_MODE:         cfg.run_mode         <= wr_data[0];
        CFG_MEASURE_TIME_MS:  cfg.measure_time_ms  <= wr_data[31:0];
        CFG_SLIP_TRIGGER_PCT: cfg.slip_trigger_pct <= wr_data[6:0];
        CFG_SLIP_DWELL_MS:    cfg.slip_dwell_ms    <= wr_data[15:0];
        CFG_MAX_FORCE_TO_MS:  cfg.force_limit_ms   <= wr_data[23:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/msr_slip.sv
// ----------------------------------------------------------------------------
// msr_slip
// Slip threshold test: 100*(cmd-meas) >= pct*cmd, zero slip for cmd <= 1.
// ----------------------------------------------------------------------------
module msr_slip (
  input  logic [23:0] commanded_um,
  input  logic [23:0] measured_um,
  input  logic [6:0]  trigger_pct,
  output logic        excess
);
  import msr_pkg::*;

  logic signed [24:0] diff;
  logic signed [32:0] lhs;
  logic        [30:0] rhs;
  logic               ge;

  assign diff = $signed({1'b0, commanded_um}) - $signed({1'b0, measured_um});
  assign lhs  = 33'(diff) * 33'sd100;
  assign rhs  = 31'(trigger_pct) * 31'(commanded_um);
  assign ge   = lhs >= $signed({2'b00, rhs});

  assign excess = (commanded_um <= 24'd1) ? (trigger_pct == 7'd0) : ge;

endmodule

// File: src/msr_seq.sv
// ----------------------------------------------------------------------------
// msr_seq
// Run state machine, counters and per-item result logic.
// ----------------------------------------------------------------------------
module msr_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  msr_pkg::in_item_t  item,
  input  msr_pkg::cfg_t      cfg,
  output msr_pkg::out_item_t result
);
  import msr_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] elapsed;
  logic [31:0] elapsed_next;
  logic [31:0] hold;
  logic [31:0] hold_next;
  logic        above;
  logic        above_next;
  logic        locked;
  logic        locked_next;

  logic [31:0]        elapsed_inc;
  logic [31:0]        hold_inc;
  logic               slip_hit;
  logic signed [13:0] temp_s;
  logic signed [13:0] tgt_s;
  logic               in_band;
  logic               begin_p;
  logic [1:0]         reason;
  logic               excess_out;

  msr_slip u_slip (
    .commanded_um (item.commanded_um),
    .measured_um  (item.measured_um),
    .trigger_pct  (cfg.slip_trigger_pct),
    .excess       (slip_hit)
  );

  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 32'd1;
  assign hold_inc    = (above && hold != '1) ? hold + 32'd1 : hold;
  assign temp_s      = $signed({2'b00, item.temp_sample});
  assign tgt_s       = $signed({2'b00, cfg.target_temp});
  assign in_band     = item.temp_valid && (temp_s >= tgt_s - TEMP_BAND)
                       && (temp_s <= tgt_s + TEMP_BAND);

  always_comb begin
    phase_next = phase;
    if (item.command == CMD_START) begin
      phase_next = PH_HEAT;
    end else begin
      case (phase)
        PH_HEAT: if (in_band) phase_next = PH_MEAS;
        PH_MEAS: if (reason != STOP_NONE) phase_next = PH_IDLE;
        default: ;
      endcase
    end
  end

  always_comb begin
    elapsed_next = elapsed;
    hold_next    = hold;
    above_next   = above;
    locked_next  = locked;
    begin_p      = 1'b0;
    reason       = STOP_NONE;
    if (item.command == CMD_START) begin
      elapsed_next = '0;
      hold_next    = '0;
      above_next   = 1'b0;
      locked_next  = 1'b0;
    end else begin
      case (phase)
        PH_HEAT: begin
          if (in_band) begin
            elapsed_next = '0;
            hold_next    = '0;
            above_next   = 1'b0;
            locked_next  = (cfg.run_mode != MODE_TIMED);
            begin_p      = 1'b1;
          end
        end
        PH_MEAS: begin
          elapsed_next = elapsed_inc;
          if (cfg.run_mode == MODE_TIMED) begin
            if (cfg.measure_time_ms != 32'd0 && elapsed_inc >= cfg.measure_time_ms)
              reason = STOP_TIME;
          end else begin
            hold_next = hold_inc;
            if (item.slip_valid) begin
              if (slip_hit) begin
                if (!above) begin
                  above_next = 1'b1;
                  hold_next  = '0;
                end
                if (hold_next >= {16'd0, cfg.slip_dwell_ms})
                  reason = STOP_SLIP;
              end else begin
                above_next = 1'b0;
                hold_next  = '0;
              end
            end
            if (reason == STOP_NONE && elapsed_inc >= {8'd0, cfg.force_limit_ms})
              reason = STOP_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
    excess_out = above_next;
    if (reason != STOP_NONE) begin
      elapsed_next = '0;
      hold_next    = '0;
      above_next   = 1'b0;
      locked_next  = 1'b0;
    end
  end

  always_comb begin
    result.phase          = phase_next;
    result.heater_allowed = (phase_next != PH_IDLE) && !locked_next;
    result.begin_pulse    = begin_p;
    result.end_pulse      = (reason != STOP_NONE);
    result.stop_reason    = reason;
    result.slip_excess    = excess_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      elapsed <= '0;
      hold    <= '0;
      above   <= 1'b0;
      locked  <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
      hold    <= hold_next;
      above   <= above_next;
      locked  <= locked_next;
    end
  end

endmodule

// File: src/measurement_run_sequencer.sv
// ----------------------------------------------------------------------------
// measurement_run_sequencer
// Heating / measuring run sequencer for an extrusion test rig.
//
// Input channel (in_valid/in_stall/in_data): one beat per start command or
// 1 ms tick. Output channel (out_valid/out_stall/out_data): exactly one
// result beat per input beat, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; write only while no beat is in flight.
//
// An accepted beat lands in the input register, is evaluated against the
// run state once the output register can take it, and is written to the
// output register together with the state update, which sets out_valid.
// Throughput is one beat per cycle while out_stall is low, set by the
// single evaluation stage.
// When out_stall holds the output register full, the input register holds
// its beat and in_stall rises; nothing is dropped.
// Reset (rst, synchronous) empties both registers, returns to idle and
// loads the default configuration.
// ----------------------------------------------------------------------------
module measurement_run_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  msr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output msr_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msr_pkg::*;

  logic      in_full;
  in_item_t  in_reg;
  logic      adv;
  logic      in_take;
  cfg_t      cfg;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign adv       = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !adv;
  assign in_take   = in_valid && !in_stall;

  msr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  msr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (adv),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  a_begin_meas: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.begin_pulse |-> out_data.phase == PH_MEAS && !out_data.end_pulse)
    else $error("begin beat not in measuring phase");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_pulse
      |-> out_data.phase == PH_IDLE && out_data.stop_reason != STOP_NONE
          && !out_data.heater_allowed)
    else $error("end beat inconsistent");

  a_reason_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.end_pulse |-> out_data.stop_reason == STOP_NONE)
    else $error("stop reason without end");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    in_full && !adv |=> in_full && $stable(in_reg))
    else $error("held input beat lost");

endmodule

// File: verif/measurement_run_sequencer_tb.sv
// ----------------------------------------------------------------------------
// measurement_run_sequencer testbench
// Drives start and tick beats through the sequencer, takes each expected
// result beat from the directed row or from a cycle-free model of the run
// state, and compares field by field. A short directed sweep covers band
// edges, every stop reason and mid-run register changes; random phases
// then vary the settings and the idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import msr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam cfg_t CFG_DEFAULT = '{12'd1800, MODE_TIMED, 32'd0, 7'd5, 16'd2000, 24'd120000};
  localparam int RAND_PHASES = 8;
  localparam int BEATS_PER_PHASE = 125;
  localparam int LONG_HOLD = 200;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } stim_row_t;

  typedef struct {
    logic      typed;
    out_item_t val;
  } row_want_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predicted run state and register mirror
  cfg_t m_cfg = CFG_DEFAULT;
  phase_t m_phase = PH_IDLE;
  logic [31:0] m_elapsed = '0;
  logic [31:0] m_hold = '0;
  logic m_slip_above = 1'b0;
  logic m_heat_lock = 1'b0;

  out_item_t pending_results[$];
  row_want_t typed_wants[$];
  stim_row_t stim_rows[$];
  int n_fail = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;

  measurement_run_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void clear_run();
    m_elapsed = '0;
    m_hold = '0;
    m_slip_above = 1'b0;
    m_heat_lock = 1'b0;
  endfunction

  function automatic out_item_t step_sequencer(in_item_t it);
    out_item_t r;
    logic [1:0] why;
    int lo, hi;
    longint c, ms;
    logic exc;
    r = '0;
    why = STOP_NONE;
    if (it.command == CMD_START) begin
      clear_run();
      m_phase = PH_HEAT;
    end else if (m_phase == PH_HEAT) begin
      lo = int'(m_cfg.target_temp) - int'(TEMP_BAND);
      hi = int'(m_cfg.target_temp) + int'(TEMP_BAND);
      if (it.temp_valid && int'(it.temp_sample) >= lo && int'(it.temp_sample) <= hi) begin
        clear_run();
        m_phase = PH_MEAS;
        m_heat_lock = (m_cfg.run_mode == MODE_PEAK_FORCE);
        r.begin_pulse = 1'b1;
      end
    end else if (m_phase == PH_MEAS) begin
      m_elapsed = sat_inc(m_elapsed);
      if (m_cfg.run_mode == MODE_TIMED) begin
        if (m_cfg.measure_time_ms != 0 && m_elapsed >= m_cfg.measure_time_ms) why = STOP_TIME;
      end else begin
        if (m_slip_above) m_hold = sat_inc(m_hold);
        if (it.slip_valid) begin
          c = longint'(it.commanded_um);
          ms = longint'(it.measured_um);
          if (c <= 1) exc = (m_cfg.slip_trigger_pct == 0);
          else exc = (100 * (c - ms) >= longint'(m_cfg.slip_trigger_pct) * c);
          if (exc) begin
            if (!m_slip_above) begin
              m_slip_above = 1'b1;
              m_hold = '0;
            end
            if (m_hold >= 32'(m_cfg.slip_dwell_ms)) why = STOP_SLIP;
          end else begin
            m_slip_above = 1'b0;
            m_hold = '0;
          end
        end
        if (why == STOP_NONE && m_elapsed >= 32'(m_cfg.force_limit_ms)) why = STOP_TIMEOUT;
      end
    end
    r.slip_excess = m_slip_above;
    if (why != STOP_NONE) begin
      r.end_pulse = 1'b1;
      m_phase = PH_IDLE;
      clear_run();
    end
    r.phase = m_phase;
    r.heater_allowed = (m_phase != PH_IDLE) && !m_heat_lock;
    r.stop_reason = why;
    return r;
  endfunction

  function automatic in_item_t mk_in(logic cm, int tv, int temp, int sv, int c, int m);
    in_item_t it;
    it.command = cm;
    it.temp_valid = tv[0];
    it.temp_sample = temp[11:0];
    it.slip_valid = sv[0];
    it.commanded_um = c[23:0];
    it.measured_um = m[23:0];
    return it;
  endfunction

  function automatic out_item_t mk_out(phase_t ph, int heat, int b, int e,
                                       logic [1:0] why, int x);
    out_item_t r;
    r.phase = ph;
    r.heater_allowed = heat[0];
    r.begin_pulse = b[0];
    r.end_pulse = e[0];
    r.stop_reason = why;
    r.slip_excess = x[0];
    return r;
  endfunction

  // mostly in-band temperatures and lengths near the slip threshold
  function automatic in_item_t gen_item();
    in_item_t it;
    longint c, thr, ms;
    int t;
    it.command = ($urandom_range(99) < 3) ? CMD_START : CMD_TICK;
    it.temp_valid = 1'($urandom_range(1));
    if ($urandom_range(9) < 6) begin
      t = int'(m_cfg.target_temp) + int'($urandom_range(42)) - 21;
      if (t < 0) t = 0;
    end else begin
      t = int'($urandom_range(4095));
    end
    it.temp_sample = t[11:0];
    it.slip_valid = ($urandom_range(9) < 7);
    case ($urandom_range(9))
      0: c = longint'($urandom_range(2));
      1: c = 64'hFFFFFF;
      default: c = longint'($urandom_range(24'hFFFFFF));
    endcase
    thr = c - (longint'(m_cfg.slip_trigger_pct) * c) / 100;
    case ($urandom_range(9))
      0: ms = longint'($urandom_range(24'hFFFFFF));
      1: ms = c + longint'($urandom_range(1000));
      default: ms = thr + longint'($urandom_range(4)) - 3;
    endcase
    if (ms < 0) ms = 0;
    if (ms > 64'hFFFFFF) ms = 64'hFFFFFF;
    it.commanded_um = c[23:0];
    it.measured_um = ms[23:0];
    return it;
  endfunction

  task automatic check_field(string fname, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", fname, e, a);
      n_fail++;
    end
  endtask

  // called at a falling edge; leaves valid high on return
  task automatic send_beat(in_item_t it, logic typed, out_item_t want);
    row_want_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    w.typed = typed;
    w.val = want;
    typed_wants.push_back(w);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TARGET_TEMP:      m_cfg.target_temp = val[11:0];
      CFG_RUN_MODE:         m_cfg.run_mode = val[0];
      CFG_MEASURE_TIME_MS:  m_cfg.measure_time_ms = val;
      CFG_SLIP_TRIGGER_PCT: m_cfg.slip_trigger_pct = val[6:0];
      CFG_SLIP_DWELL_MS:    m_cfg.slip_dwell_ms = val[15:0];
      CFG_MAX_FORCE_TO_MS:  m_cfg.force_limit_ms = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // drop valid, wait for every pending beat, then let both registers drain
  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver: random stall plus requested long hold-offs
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watch
    row_want_t w;
    out_item_t pred;
    out_item_t exp_r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = step_sequencer(in_data);
        w = typed_wants.pop_front();
        pending_results.push_back(w.typed ? w.val : pred);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending");
          n_fail++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("phase", 32'(exp_r.phase), 32'(out_data.phase));
          check_field("heater_allowed", 32'(exp_r.heater_allowed),
                      32'(out_data.heater_allowed));
          check_field("begin_pulse", 32'(exp_r.begin_pulse), 32'(out_data.begin_pulse));
          check_field("end_pulse", 32'(exp_r.end_pulse), 32'(out_data.end_pulse));
          check_field("stop_reason", 32'(exp_r.stop_reason), 32'(out_data.stop_reason));
          check_field("slip_excess", 32'(exp_r.slip_excess), 32'(out_data.slip_excess));
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] tgt, mode, mt, pct, hold, tmo;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    stim_rows = '{
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 4095, 1, 24'hFFFFFF, 24'hFFFFFF), 1'b1,
        mk_out(PH_IDLE, 0, 0, 0, STOP_NONE, 0), '0, '0},
      '{ROW_BEAT, mk_in(CMD_START, 0, 0, 0, 0, 0), 1'b1,
        mk_out(PH_HEAT, 1, 0, 0, STOP_NONE, 0), '0, '0},
      // band edges; slip data ignored while heating
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1779, 1, 1000, 0), 1'b1,
        mk_out(PH_HEAT, 1, 0, 0, STOP_NONE, 0), '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1821, 0, 0, 0), 1'b1,
        mk_out(PH_HEAT, 1, 0, 0, STOP_NONE, 0), '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1780, 0, 0, 0), 1'b1,
        mk_out(PH_MEAS, 1, 1, 0, STOP_NONE, 0), '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 0, 0, 0, 0, 0), 1'b0, '0, '0, '0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_MEASURE_TIME_MS, 32'd2},
      '{ROW_BEAT, mk_in(CMD_TICK, 0, 0, 1, 1000, 0), 1'b1,
        mk_out(PH_IDLE, 0, 0, 1, STOP_TIME, 0), '0, '0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_RUN_MODE, 32'(MODE_PEAK_FORCE)},
      '{ROW_CFG, '0, 1'b0, '0, CFG_SLIP_DWELL_MS, 32'd0},
      '{ROW_BEAT, mk_in(CMD_START, 0, 0, 0, 0, 0), 1'b0, '0, '0, '0},
      // begin beat takes no stop decision even with excessive slip
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1820, 1, 1000, 0), 1'b1,
        mk_out(PH_MEAS, 0, 1, 0, STOP_NONE, 0), '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 0, 0, 1, 1000, 950), 1'b1,
        mk_out(PH_IDLE, 0, 0, 1, STOP_SLIP, 1), '0, '0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_MAX_FORCE_TO_MS, 32'd0},
      '{ROW_BEAT, mk_in(CMD_START, 0, 0, 0, 0, 0), 1'b0, '0, '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1800, 0, 0, 0), 1'b0, '0, '0, '0},
      // tiny commanded length counts as zero slip
      '{ROW_BEAT, mk_in(CMD_TICK, 0, 0, 1, 1, 0), 1'b1,
        mk_out(PH_IDLE, 0, 0, 1, STOP_TIMEOUT, 0), '0, '0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_SLIP_TRIGGER_PCT, 32'd0},
      '{ROW_BEAT, mk_in(CMD_START, 0, 0, 0, 0, 0), 1'b0, '0, '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1800, 0, 0, 0), 1'b0, '0, '0, '0},
      // slip and timeout on the same beat: slip wins
      '{ROW_BEAT, mk_in(CMD_TICK, 0, 0, 1, 0, 0), 1'b1,
        mk_out(PH_IDLE, 0, 0, 1, STOP_SLIP, 1), '0, '0},
      '{ROW_BEAT, mk_in(CMD_START, 0, 0, 0, 0, 0), 1'b0, '0, '0, '0},
      '{ROW_BEAT, mk_in(CMD_TICK, 1, 1800, 0, 0, 0), 1'b1,
        mk_out(PH_MEAS, 0, 1, 0, STOP_NONE, 0), '0, '0},
      // mode flip mid-run: timed rule applies, heater lock stays
      '{ROW_CFG, '0, 1'b0, '0, CFG_RUN_MODE, 32'(MODE_TIMED)},
      '{ROW_BEAT, mk_in(CMD_TICK, 0, 0, 1, 0, 0), 1'b0, '0, '0, '0},
      '{ROW_BEAT, mk_in(CMD_START, 1, 4095, 1, 24'hFFFFFF, 0), 1'b1,
        mk_out(PH_HEAT, 1, 0, 0, STOP_NONE, 0), '0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_beat(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
      end
    end
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      case (p)
        0: begin
          tgt = 3000; mode = 32'(MODE_TIMED); mt = 32'hFFFFFFFF;
          pct = 100; hold = 65535; tmo = 32'hFFFFFF;
        end
        1: begin
          tgt = 0; mode = 32'(MODE_PEAK_FORCE); mt = 0; pct = 0; hold = 0; tmo = 0;
        end
        default: begin
          tgt = (p == 3) ? 3000 : $urandom_range(3000);
          mode = p % 2;
          mt = $urandom_range(25);
          pct = $urandom_range(100);
          hold = $urandom_range(6);
          tmo = $urandom_range(40);
        end
      endcase
      // junk above each register's width must be dropped
      write_reg(CFG_TARGET_TEMP, tgt | ($urandom << 12));
      write_reg(CFG_RUN_MODE, mode | ($urandom << 1));
      write_reg(CFG_MEASURE_TIME_MS, mt);
      write_reg(CFG_SLIP_TRIGGER_PCT, pct | ($urandom << 7));
      write_reg(CFG_SLIP_DWELL_MS, hold | ($urandom << 16));
      write_reg(CFG_MAX_FORCE_TO_MS, tmo | ($urandom << 24));
      write_reg(CFG_IDX_SPARE_LO, $urandom);
      write_reg(CFG_IDX_SPARE_HI, $urandom);

      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        if (i == BEATS_PER_PHASE / 2) settle();
        if (p == 2 && i == 10) hold_reqs++;
        send_beat(gen_item(), 1'b0, '0);
      end
      settle();
    end

    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/msr_pkg.sv
src/msr_cfg.sv
src/msr_slip.sv
src/msr_seq.sv
src/measurement_run_sequencer.sv
verif/measurement_run_sequencer_tb.sv
